// File: rtl/lwsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwsc_pkg
// Shared types and constants of the sector cache directory.
// ----------------------------------------------------------------------------
package lwsc_pkg;

    // Width of the reported way field.
    localparam int WAY_FIELD_W = 3;

    // Control and status flags of one result.
    typedef struct packed {
        logic writeback_needed;
        logic fill_needed;
        logic hit;
    } res_flags_t;

    // Back end sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_UPDATE = 3'b100
    } back_state_t;

endpackage

// File: rtl/lwsc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwsc_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module lwsc_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/lwsc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwsc_front
// Request intake: decodes the command and sector of each request and holds
// it in a two-entry queue until the back end takes it.
// ----------------------------------------------------------------------------
module lwsc_front
    import lwsc_pkg::*;
#(
    parameter int SECTOR_BITS = 10
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [((SECTOR_BITS+1+7)/8)*8-1:0] in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   out_write,
    output logic [SECTOR_BITS-1:0] out_sector
);

    logic                   q_write_reg  [2];
    logic [SECTOR_BITS-1:0] q_sector_reg [2];
    logic                   wr_ptr_reg, wr_ptr_next;
    logic                   rd_ptr_reg, rd_ptr_next;
    logic [1:0]             count_reg, count_next;
    logic                   push, pop;
    logic                   dec_write;
    logic [SECTOR_BITS-1:0] dec_sector;

    // Command in the lowest bit, sector above it.
    assign dec_write  = in_data[0];
    assign dec_sector = in_data[SECTOR_BITS:1];

    assign in_ready   = (count_reg != 2'd2);
    assign out_valid  = (count_reg != 2'd0);
    assign push       = in_valid && in_ready;
    assign pop        = out_valid && out_ready;
    assign out_write  = q_write_reg[rd_ptr_reg];
    assign out_sector = q_sector_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_write_reg[wr_ptr_reg]  <= dec_write;
            q_sector_reg[wr_ptr_reg] <= dec_sector;
        end
    end

endmodule

// File: rtl/lwsc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwsc_back
// Directory engine: scans the ways one per cycle for a hit, a free way and
// the least recently used way, then updates tags, flags and ranks and
// registers the result.
// ----------------------------------------------------------------------------
module lwsc_back
    import lwsc_pkg::*;
#(
    parameter int WAYS        = 8,
    parameter int SECTOR_BITS = 10
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_ready,
    input  logic                   req_write,
    input  logic [SECTOR_BITS-1:0] req_sector,
    output logic                   res_valid,
    input  logic                   res_ready,
    output res_flags_t             res_flags,
    output logic [WAY_FIELD_W-1:0] res_way,
    output logic [SECTOR_BITS-1:0] res_wb_sector
);

    localparam int IW = $clog2(WAYS);
    localparam logic [IW-1:0] LAST_WAY = IW'(WAYS - 1);

    back_state_t state_reg, state_next;

    // Request being served.
    logic                   cur_write_reg;
    logic [SECTOR_BITS-1:0] cur_sector_reg;

    // Directory state.
    logic [WAYS-1:0] valid_reg, valid_next;
    logic [WAYS-1:0] dirty_reg, dirty_next;
    logic [IW-1:0]   rank_reg [WAYS];
    logic [IW-1:0]   rank_next [WAYS];

    // Scan pipeline: address issued to the tag RAM, then compared in the next cycle.
    logic [IW-1:0] rd_idx_reg, rd_idx_next;
    logic          rd_done_reg, rd_done_next;
    logic          cmp_vld_reg, cmp_vld_next;
    logic [IW-1:0] cmp_idx_reg, cmp_idx_next;

    // Scan findings.
    logic                   hit_found_reg, hit_found_next;
    logic                   inv_found_reg, inv_found_next;
    logic [IW-1:0]          hit_way_reg, hit_way_next;
    logic [IW-1:0]          hit_rank_reg, hit_rank_next;
    logic [IW-1:0]          inv_way_reg, inv_way_next;
    logic [IW-1:0]          inv_rank_reg, inv_rank_next;
    logic [IW-1:0]          lru_way_reg, lru_way_next;
    logic [IW-1:0]          lru_rank_reg, lru_rank_next;
    logic [SECTOR_BITS-1:0] lru_tag_reg, lru_tag_next;

    // Result register.
    logic                   res_valid_reg, res_valid_next;
    res_flags_t             res_flags_reg;
    logic [WAY_FIELD_W-1:0] res_way_reg;
    logic [SECTOR_BITS-1:0] res_wb_sector_reg;

    logic                   start;
    logic                   eval;
    logic                   tag_match;
    logic                   cmp_valid_bit;
    logic [IW-1:0]          cmp_rank;
    logic [SECTOR_BITS-1:0] tag_rdata;
    logic                   do_update;
    logic [IW-1:0]          upd_way;
    logic [IW-1:0]          upd_rank;
    logic                   upd_wb;

    lwsc_ram #(
        .WIDTH (SECTOR_BITS),
        .DEPTH (WAYS)
    ) u_tag_ram (
        .clk   (clk),
        .we    (do_update && !hit_found_reg),
        .waddr (upd_way),
        .wdata (cur_sector_reg),
        .raddr (rd_idx_reg),
        .rdata (tag_rdata)
    );

    assign req_ready     = (state_reg == ST_IDLE);
    assign start         = req_valid && req_ready;
    assign eval          = (state_reg == ST_SCAN) && cmp_vld_reg;
    assign cmp_rank      = rank_reg[cmp_idx_reg];
    assign cmp_valid_bit = valid_reg[cmp_idx_reg];
    assign tag_match     = cmp_valid_bit && (tag_rdata == cur_sector_reg);

    // With every way valid the victim is the one holding the highest rank.
    always_comb
    begin
        if (hit_found_reg)
        begin
            upd_way  = hit_way_reg;
            upd_rank = hit_rank_reg;
        end
        else if (inv_found_reg)
        begin
            upd_way  = inv_way_reg;
            upd_rank = inv_rank_reg;
        end
        else
        begin
            upd_way  = lru_way_reg;
            upd_rank = lru_rank_reg;
        end
    end

    assign upd_wb    = !hit_found_reg && !inv_found_reg && dirty_reg[lru_way_reg];
    assign do_update = (state_reg == ST_UPDATE) && (!res_valid_reg || res_ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (eval && (cmp_idx_reg == LAST_WAY))
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (do_update)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rd_idx_next  = rd_idx_reg;
        rd_done_next = rd_done_reg;
        cmp_vld_next = 1'b0;
        cmp_idx_next = cmp_idx_reg;
        if (start)
        begin
            rd_idx_next  = '0;
            rd_done_next = 1'b0;
        end
        else if ((state_reg == ST_SCAN) && !rd_done_reg)
        begin
            cmp_vld_next = 1'b1;
            cmp_idx_next = rd_idx_reg;
            if (rd_idx_reg == LAST_WAY)
            begin
                rd_done_next = 1'b1;
            end
            else
            begin
                rd_idx_next = rd_idx_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        hit_found_next = hit_found_reg;
        inv_found_next = inv_found_reg;
        hit_way_next   = hit_way_reg;
        hit_rank_next  = hit_rank_reg;
        inv_way_next   = inv_way_reg;
        inv_rank_next  = inv_rank_reg;
        lru_way_next   = lru_way_reg;
        lru_rank_next  = lru_rank_reg;
        lru_tag_next   = lru_tag_reg;
        if (start)
        begin
            hit_found_next = 1'b0;
            inv_found_next = 1'b0;
        end
        else if (eval)
        begin
            if (tag_match && !hit_found_reg)
            begin
                hit_found_next = 1'b1;
                hit_way_next   = cmp_idx_reg;
                hit_rank_next  = cmp_rank;
            end
            if (!cmp_valid_bit && !inv_found_reg)
            begin
                inv_found_next = 1'b1;
                inv_way_next   = cmp_idx_reg;
                inv_rank_next  = cmp_rank;
            end
            // A strict compare keeps the lowest-numbered way on a tie.
            if ((cmp_idx_reg == '0) || (cmp_rank > lru_rank_reg))
            begin
                lru_way_next  = cmp_idx_reg;
                lru_rank_next = cmp_rank;
                lru_tag_next  = tag_rdata;
            end
        end
    end

    // The served way becomes most recent; every way more recent than it ages.
    always_comb
    begin
        valid_next = valid_reg;
        dirty_next = dirty_reg;
        for (int i = 0; i < WAYS; i++)
        begin
            rank_next[i] = rank_reg[i];
            if (do_update)
            begin
                if (upd_way == IW'(i))
                begin
                    valid_next[i] = 1'b1;
                    dirty_next[i] = cur_write_reg || (hit_found_reg && dirty_reg[i]);
                    rank_next[i]  = '0;
                end
                else if (rank_reg[i] < upd_rank)
                begin
                    rank_next[i] = rank_reg[i] + 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (do_update)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            dirty_reg     <= '0;
            for (int i = 0; i < WAYS; i++)
            begin
                rank_reg[i] <= IW'(i);
            end
            rd_idx_reg    <= '0;
            rd_done_reg   <= 1'b0;
            cmp_vld_reg   <= 1'b0;
            hit_found_reg <= 1'b0;
            inv_found_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            dirty_reg     <= dirty_next;
            for (int i = 0; i < WAYS; i++)
            begin
                rank_reg[i] <= rank_next[i];
            end
            rd_idx_reg    <= rd_idx_next;
            rd_done_reg   <= rd_done_next;
            cmp_vld_reg   <= cmp_vld_next;
            hit_found_reg <= hit_found_next;
            inv_found_reg <= inv_found_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            cur_write_reg  <= req_write;
            cur_sector_reg <= req_sector;
        end
        cmp_idx_reg  <= cmp_idx_next;
        hit_way_reg  <= hit_way_next;
        hit_rank_reg <= hit_rank_next;
        inv_way_reg  <= inv_way_next;
        inv_rank_reg <= inv_rank_next;
        lru_way_reg  <= lru_way_next;
        lru_rank_reg <= lru_rank_next;
        lru_tag_reg  <= lru_tag_next;
        if (do_update)
        begin
            res_flags_reg.hit              <= hit_found_reg;
            res_flags_reg.fill_needed      <= !hit_found_reg;
            res_flags_reg.writeback_needed <= upd_wb;
            res_way_reg                    <= WAY_FIELD_W'(upd_way);
            res_wb_sector_reg              <= upd_wb ? lru_tag_reg : '0;
        end
    end

    assign res_valid     = res_valid_reg;
    assign res_flags     = res_flags_reg;
    assign res_way       = res_way_reg;
    assign res_wb_sector = res_wb_sector_reg;

endmodule

// File: rtl/lru_writeback_sector_cache_directory_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_writeback_sector_cache_directory_core
// Directory and LRU replacement engine of a fully associative write-back
// sector cache.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on the s_ group; each carries a read or write command and
// a sector number. For every request one result leaves on the m_ group: hit,
// the way that now holds the sector, whether a fill is needed, and whether
// the old dirty sector of the victim must first be written back.
// A request is taken into a two-entry queue. The engine then reads the tag
// store one way per cycle, set by its single read port; it then updates
// the directory and registers the result before it takes the next request
// from the queue, so requests are served one at a time.
// The result waits in its register while m_tready is low; the engine then
// holds its finished update, and the queue keeps taking up to two further
// requests before s_tready drops.
// Reset clears all valid and dirty bits and sets each way's recency rank to
// its way number. Tags need no clearing, so the block takes requests right
// after reset.
// ----------------------------------------------------------------------------
module lru_writeback_sector_cache_directory_core
    import lwsc_pkg::*;
#(
    parameter int WAYS        = 8,
    parameter int SECTOR_BITS = 10
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    // command [0], sector above it, zero padded
    input  logic [((SECTOR_BITS+1+7)/8)*8-1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // hit, way (3), fill_needed, writeback_needed, writeback_sector, zero padded
    output logic [((SECTOR_BITS+6+7)/8)*8-1:0] m_tdata
);

    localparam int OUT_W = ((SECTOR_BITS + 6 + 7) / 8) * 8;

    logic                   req_valid;
    logic                   req_ready;
    logic                   req_write;
    logic [SECTOR_BITS-1:0] req_sector;
    res_flags_t             res_flags;
    logic [WAY_FIELD_W-1:0] res_way;
    logic [SECTOR_BITS-1:0] res_wb_sector;

    lwsc_front #(
        .SECTOR_BITS (SECTOR_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_data    (s_tdata),
        .out_valid  (req_valid),
        .out_ready  (req_ready),
        .out_write  (req_write),
        .out_sector (req_sector)
    );

    lwsc_back #(
        .WAYS        (WAYS),
        .SECTOR_BITS (SECTOR_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_ready     (req_ready),
        .req_write     (req_write),
        .req_sector    (req_sector),
        .res_valid     (m_tvalid),
        .res_ready     (m_tready),
        .res_flags     (res_flags),
        .res_way       (res_way),
        .res_wb_sector (res_wb_sector)
    );

    assign m_tdata = OUT_W'({res_wb_sector, res_flags.writeback_needed,
                             res_flags.fill_needed, res_way, res_flags.hit});

endmodule

// File: rtl/lwsc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwsc_checker
// Port-level checks of the sector cache directory, bound to the top level.
// ----------------------------------------------------------------------------
module lwsc_checker #(
    parameter int SECTOR_BITS = 10
) (
    input logic clk,
    input logic rst_n,
    input logic s_tvalid,
    input logic s_tready,
    input logic m_tvalid,
    input logic m_tready,
    input logic [((SECTOR_BITS+6+7)/8)*8-1:0] m_tdata
);

    // Result bit positions.
    localparam int HIT_BIT  = 0;
    localparam int FILL_BIT = 4;
    localparam int WB_BIT   = 5;
    localparam int WB_LSB   = 6;

    // A stalled result stays put.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Every request either hits or needs a fill, never both.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[HIT_BIT] != m_tdata[FILL_BIT]))
        else $error("hit and fill flags disagree");

    // A writeback only happens on an eviction, which is always a miss.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[WB_BIT] |-> m_tdata[FILL_BIT])
        else $error("writeback reported on a hit");

    // Without a writeback the writeback sector reads as zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[WB_BIT] |-> (m_tdata[WB_LSB +: SECTOR_BITS] == '0))
        else $error("writeback sector set without a writeback");

    // The input queue holds two requests, so a request is never refused
    // in the cycle right after an idle queue accepted nothing.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> $past(s_tvalid && s_tready) || $past(!s_tready))
        else $error("request refused without a queue filling");

endmodule

bind lru_writeback_sector_cache_directory_core lwsc_checker #(
    .SECTOR_BITS (SECTOR_BITS)
) u_lwsc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
